[src/mta_pkg.sv]
package mta_pkg;

   // sizes fixed by the field formats
   localparam int MAX_VERTICES_DEF = 1024;
   localparam int IDX_W = 10;
   localparam int CRD_W = 32;
   localparam int ACC_W = 40;
   localparam int TAN_W = 16;
   localparam int CNT_W = 7;
   localparam int NUM_W = 80;
   localparam int REM_W = 64;

   // request modes
   localparam logic [1:0] MODE_LOAD = 2'd0;
   localparam logic [1:0] MODE_TRI = 2'd1;
   localparam logic [1:0] MODE_READ = 2'd2;

   // iteration counts of the shared unit
   localparam logic [CNT_W-1:0] TRI_DIV_STEPS = 7'd79;
   localparam logic [CNT_W-1:0] NRM_DIV_STEPS = 7'd39;
   localparam logic [CNT_W-1:0] SQRT_STEPS = 7'd25;
   localparam logic [NUM_W-1:0] SQRT_BIT0 = NUM_W'(1) << 48;

   localparam logic signed [ACC_W:0] COMP_LIM = 41'sh7F_FFFF_FFFF;

   typedef struct packed {
      logic [1:0] mode;
      logic [IDX_W-1:0] index_a;
      logic [IDX_W-1:0] index_b;
      logic [IDX_W-1:0] index_c;
      logic signed [CRD_W-1:0] pos_x;
      logic signed [CRD_W-1:0] pos_y;
      logic signed [CRD_W-1:0] pos_z;
      logic signed [CRD_W-1:0] tex_u;
      logic signed [CRD_W-1:0] tex_v;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0] vertex_index;
      logic signed [TAN_W-1:0] tangent_x;
      logic signed [TAN_W-1:0] tangent_y;
      logic signed [TAN_W-1:0] tangent_z;
      logic zero_length;
   } rsp_type;

   typedef struct packed {
      logic signed [CRD_W-1:0] x;
      logic signed [CRD_W-1:0] y;
      logic signed [CRD_W-1:0] z;
      logic signed [CRD_W-1:0] u;
      logic signed [CRD_W-1:0] v;
   } vtx_type;

   typedef struct packed {
      logic signed [ACC_W-1:0] x;
      logic signed [ACC_W-1:0] y;
      logic signed [ACC_W-1:0] z;
   } acc_type;

   typedef enum logic {
      OP_DIV,
      OP_SQRT
   } iter_op_type;

   typedef struct packed {
      logic start;
      iter_op_type op;
      logic [CNT_W-1:0] count;
      logic [NUM_W-1:0] dividend;
      logic [REM_W-1:0] divisor;
   } iter_req_type;

   typedef struct packed {
      logic done;
      logic [REM_W-1:0] quot;
      logic sat;
   } iter_rsp_type;

   typedef enum logic [4:0] {
      S_CLEAR,
      S_IDLE,
      S_FETCH,
      S_DIFF,
      S_MUL,
      S_DIV_START,
      S_DIV_WAIT,
      S_ACC_RD,
      S_ACC_WR,
      S_RD_ACC,
      S_NORM,
      S_SQ,
      S_SQRT_START,
      S_SQRT_WAIT,
      S_NDIV_START,
      S_NDIV_WAIT,
      S_RESP
   } state_type;

   // edge difference saturated to +-(2^31-1)
   function automatic logic signed [CRD_W-1:0] sat_diff(input logic signed [CRD_W-1:0] a,
                                                         input logic signed [CRD_W-1:0] b);
      logic signed [CRD_W:0] d;
      d = (CRD_W+1)'(a) - (CRD_W+1)'(b);
      if (d > 33'sh0_7FFF_FFFF) begin
         return 32'sh7FFF_FFFF;
      end else if (d < -33'sh0_7FFF_FFFF) begin
         return 32'sh8000_0001;
      end
      return d[CRD_W-1:0];
   endfunction

   // accumulator add, saturated to [-2^39, 2^39-1]
   function automatic logic signed [ACC_W-1:0] acc_add(input logic signed [ACC_W-1:0] a,
                                                        input logic signed [ACC_W:0] t);
      logic signed [ACC_W+1:0] s;
      s = (ACC_W+2)'(a) + (ACC_W+2)'(t);
      if (s > (ACC_W+2)'(COMP_LIM)) begin
         return COMP_LIM[ACC_W-1:0];
      end else if (s < -(ACC_W+2)'(COMP_LIM) - 42'sd1) begin
         return {1'b1, {(ACC_W-1){1'b0}}};
      end
      return s[ACC_W-1:0];
   endfunction

endpackage

[src/mesh_tangent_accumulator.sv]
// channel   direction  handshake           payload
// req       in         req_valid/req_stall mta_pkg::req_type (load, triangle, readout)
// rsp       out        rsp_valid/rsp_stall mta_pkg::rsp_type (readout only)
//
// a load is written in the cycle it is taken; a triangle holds req_stall high after it is
// taken, through three 79-step divisions in the shared iterative unit, ending early
// on a zero determinant; a readout runs up to 16 normalize shifts, a 25-step square
// root and three 39-step divisions, ending early on a zero vector.
// after reset the accumulator memory is cleared entry by entry with req_stall
// high. a finished readout waits in the output register while the next request is taken
module mesh_tangent_accumulator #(
   parameter int MAX_VERTICES = mta_pkg::MAX_VERTICES_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  mta_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_stall,
   output mta_pkg::rsp_type rsp_data
);

   localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

   // storage
   mta_pkg::vtx_type vtx_mem [MAX_VERTICES];
   mta_pkg::acc_type acc_mem [MAX_VERTICES];
   mta_pkg::vtx_type vtx_rd_ff;
   mta_pkg::acc_type acc_rd_ff;

   mta_pkg::state_type state_ff, state_in;
   logic [3:0] cnt_ff, cnt_in;
   logic [AW-1:0] clr_ff;
   logic [AW-1:0] idx_ff [3];
   mta_pkg::vtx_type vtx_ff [3];
   logic signed [31:0] e1_ff [3];
   logic signed [31:0] e2_ff [3];
   logic signed [31:0] du1_ff, dv1_ff, du2_ff, dv2_ff;
   logic signed [65:0] hold_ff;
   logic signed [64:0] res_ff [4];
   logic signed [40:0] tan_ff [3];
   logic [39:0] mag_ff [3];
   logic neg_ff [3];
   logic [49:0] sum_ff;
   logic [25:0] len_ff;
   logic signed [15:0] out_ff [3];
   logic zero_ff;
   logic [mta_pkg::IDX_W-1:0] ridx_ff;
   logic rsp_valid_ff;
   mta_pkg::rsp_type rsp_data_ff;

   logic req_acc;
   logic rsp_load;
   logic vtx_we, acc_we;
   logic [AW-1:0] vtx_ra, acc_ra, acc_wa, corner;
   mta_pkg::acc_type acc_wd;
   logic in_a, in_b, in_c;
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] prod;
   mta_pkg::iter_req_type ireq;
   mta_pkg::iter_rsp_type irsp;
   logic signed [64:0] div_num;
   logic [63:0] un, ud;
   logic [39:0] mag_or;
   logic [16:0] rnd;

   mta_mul u_mul (
      .clock(clock),
      .op_a(mul_a),
      .op_b(mul_b),
      .prod(prod)
   );

   mta_iter u_iter (
      .clock(clock),
      .reset(reset),
      .ireq(ireq),
      .irsp(irsp)
   );

   // index range checks, handshake strobes, magnitude OR and corner select
   always_comb begin
      in_a = 32'(req_data.index_a) < 32'(MAX_VERTICES);
      in_b = 32'(req_data.index_b) < 32'(MAX_VERTICES);
      in_c = 32'(req_data.index_c) < 32'(MAX_VERTICES);
      req_acc = req_valid && !req_stall;
      rsp_load = (state_ff == mta_pkg::S_RESP) && (!rsp_valid_ff || !rsp_stall);
      mag_or = mag_ff[0] | mag_ff[1] | mag_ff[2];
      case (cnt_ff[1:0])
         2'd0: corner = idx_ff[0];
         2'd1: corner = idx_ff[1];
         default: corner = idx_ff[2];
      endcase
   end

   // divider operands of the current component and quotient rounding
   always_comb begin
      case (cnt_ff[1:0])
         2'd0: div_num = res_ff[1];
         2'd1: div_num = res_ff[2];
         default: div_num = res_ff[3];
      endcase
      un = div_num[64] ? 64'(-div_num) : div_num[63:0];
      ud = res_ff[0][64] ? 64'(-res_ff[0]) : res_ff[0][63:0];
      rnd = irsp.quot[16:0] + 17'd1;
   end

   // multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == mta_pkg::S_MUL) begin
         case (cnt_ff)
            4'd0: begin mul_a = 33'(du1_ff); mul_b = 33'(dv2_ff); end
            4'd1: begin mul_a = 33'(du2_ff); mul_b = 33'(dv1_ff); end
            4'd2: begin mul_a = 33'(dv2_ff); mul_b = 33'(e1_ff[0]); end
            4'd3: begin mul_a = 33'(dv1_ff); mul_b = 33'(e2_ff[0]); end
            4'd4: begin mul_a = 33'(dv2_ff); mul_b = 33'(e1_ff[1]); end
            4'd5: begin mul_a = 33'(dv1_ff); mul_b = 33'(e2_ff[1]); end
            4'd6: begin mul_a = 33'(dv2_ff); mul_b = 33'(e1_ff[2]); end
            4'd7: begin mul_a = 33'(dv1_ff); mul_b = 33'(e2_ff[2]); end
            default: begin mul_a = '0; mul_b = '0; end
         endcase
      end else if (state_ff == mta_pkg::S_SQ) begin
         case (cnt_ff)
            4'd0: begin
               mul_a = $signed({9'b0, mag_ff[0][23:0]});
               mul_b = $signed({9'b0, mag_ff[0][23:0]});
            end
            4'd1: begin
               mul_a = $signed({9'b0, mag_ff[1][23:0]});
               mul_b = $signed({9'b0, mag_ff[1][23:0]});
            end
            4'd2: begin
               mul_a = $signed({9'b0, mag_ff[2][23:0]});
               mul_b = $signed({9'b0, mag_ff[2][23:0]});
            end
            default: begin mul_a = '0; mul_b = '0; end
         endcase
      end
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mta_pkg::S_CLEAR;
         cnt_ff <= '0;
         clr_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         if (state_ff == mta_pkg::S_CLEAR) begin
            clr_ff <= clr_ff + AW'(1);
         end
      end
   end

   // sequencer: next state, memory ports, shared unit requests
   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      req_stall = (state_ff != mta_pkg::S_IDLE);
      vtx_we = 1'b0;
      acc_we = 1'b0;
      vtx_ra = (cnt_ff == 4'd0) ? idx_ff[1] : idx_ff[2];
      acc_ra = corner;
      acc_wa = corner;
      acc_wd.x = mta_pkg::acc_add(acc_rd_ff.x, tan_ff[0]);
      acc_wd.y = mta_pkg::acc_add(acc_rd_ff.y, tan_ff[1]);
      acc_wd.z = mta_pkg::acc_add(acc_rd_ff.z, tan_ff[2]);
      ireq.start = 1'b0;
      ireq.op = mta_pkg::OP_DIV;
      ireq.count = mta_pkg::TRI_DIV_STEPS;
      ireq.dividend = {un[62:0], 17'b0};
      ireq.divisor = ud;
      case (state_ff)
         mta_pkg::S_CLEAR: begin
            acc_we = 1'b1;
            acc_wa = clr_ff;
            acc_wd = '0;
            if (clr_ff == AW'(MAX_VERTICES - 1)) begin
               state_in = mta_pkg::S_IDLE;
            end
         end
         mta_pkg::S_IDLE: begin
            vtx_ra = AW'(req_data.index_a);
            acc_ra = AW'(req_data.index_a);
            acc_wa = AW'(req_data.index_a);
            acc_wd = '0;
            cnt_in = '0;
            if (req_acc) begin
               case (req_data.mode)
                  mta_pkg::MODE_LOAD: begin
                     vtx_we = in_a;
                     acc_we = in_a;
                  end
                  mta_pkg::MODE_TRI: begin
                     if (in_a && in_b && in_c) begin
                        state_in = mta_pkg::S_FETCH;
                     end
                  end
                  mta_pkg::MODE_READ: begin
                     state_in = in_a ? mta_pkg::S_RD_ACC : mta_pkg::S_RESP;
                  end
                  default: state_in = mta_pkg::S_IDLE;
               endcase
            end
         end
         mta_pkg::S_FETCH: begin
            if (cnt_ff == 4'd2) begin
               state_in = mta_pkg::S_DIFF;
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         mta_pkg::S_DIFF: begin
            cnt_in = '0;
            state_in = mta_pkg::S_MUL;
         end
         mta_pkg::S_MUL: begin
            if (cnt_ff == 4'd8) begin
               cnt_in = '0;
               state_in = mta_pkg::S_DIV_START;
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         mta_pkg::S_DIV_START: begin
            if (res_ff[0] == '0) begin
               state_in = mta_pkg::S_IDLE;
            end else begin
               ireq.start = 1'b1;
               state_in = mta_pkg::S_DIV_WAIT;
            end
         end
         mta_pkg::S_DIV_WAIT: begin
            if (irsp.done) begin
               if (cnt_ff == 4'd2) begin
                  cnt_in = '0;
                  state_in = mta_pkg::S_ACC_RD;
               end else begin
                  cnt_in = cnt_ff + 4'd1;
                  state_in = mta_pkg::S_DIV_START;
               end
            end
         end
         mta_pkg::S_ACC_RD: begin
            state_in = mta_pkg::S_ACC_WR;
         end
         mta_pkg::S_ACC_WR: begin
            acc_we = 1'b1;
            if (cnt_ff == 4'd2) begin
               state_in = mta_pkg::S_IDLE;
            end else begin
               cnt_in = cnt_ff + 4'd1;
               state_in = mta_pkg::S_ACC_RD;
            end
         end
         mta_pkg::S_RD_ACC: begin
            state_in = mta_pkg::S_NORM;
         end
         mta_pkg::S_NORM: begin
            cnt_in = '0;
            if (mag_or[39:24] == '0) begin
               state_in = (mag_or == '0) ? mta_pkg::S_RESP : mta_pkg::S_SQ;
            end
         end
         mta_pkg::S_SQ: begin
            if (cnt_ff == 4'd3) begin
               state_in = mta_pkg::S_SQRT_START;
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         mta_pkg::S_SQRT_START: begin
            ireq.start = 1'b1;
            ireq.op = mta_pkg::OP_SQRT;
            ireq.count = mta_pkg::SQRT_STEPS;
            ireq.dividend = mta_pkg::NUM_W'(sum_ff);
            state_in = mta_pkg::S_SQRT_WAIT;
         end
         mta_pkg::S_SQRT_WAIT: begin
            cnt_in = '0;
            if (irsp.done) begin
               state_in = mta_pkg::S_NDIV_START;
            end
         end
         mta_pkg::S_NDIV_START: begin
            ireq.start = 1'b1;
            ireq.count = mta_pkg::NRM_DIV_STEPS;
            ireq.divisor = 64'(len_ff);
            case (cnt_ff[1:0])
               2'd0: ireq.dividend = {mag_ff[0][23:0], 56'b0};
               2'd1: ireq.dividend = {mag_ff[1][23:0], 56'b0};
               default: ireq.dividend = {mag_ff[2][23:0], 56'b0};
            endcase
            state_in = mta_pkg::S_NDIV_WAIT;
         end
         mta_pkg::S_NDIV_WAIT: begin
            if (irsp.done) begin
               if (cnt_ff == 4'd2) begin
                  state_in = mta_pkg::S_RESP;
               end else begin
                  cnt_in = cnt_ff + 4'd1;
                  state_in = mta_pkg::S_NDIV_START;
               end
            end
         end
         mta_pkg::S_RESP: begin
            if (rsp_load) begin
               state_in = mta_pkg::S_IDLE;
            end
         end
         default: state_in = mta_pkg::S_IDLE;
      endcase
   end

   // vertex memory
   always_ff @(posedge clock) begin
      if (vtx_we) begin
         vtx_mem[AW'(req_data.index_a)] <= {req_data.pos_x, req_data.pos_y, req_data.pos_z,
                                            req_data.tex_u, req_data.tex_v};
      end
      vtx_rd_ff <= vtx_mem[vtx_ra];
   end

   // accumulator memory
   always_ff @(posedge clock) begin
      if (acc_we) begin
         acc_mem[acc_wa] <= acc_wd;
      end
      acc_rd_ff <= acc_mem[acc_ra];
   end

   // triangle datapath
   always_ff @(posedge clock) begin
      if (req_acc) begin
         idx_ff[0] <= AW'(req_data.index_a);
         idx_ff[1] <= AW'(req_data.index_b);
         idx_ff[2] <= AW'(req_data.index_c);
         ridx_ff <= req_data.index_a;
      end
      if (state_ff == mta_pkg::S_FETCH) begin
         case (cnt_ff[1:0])
            2'd0: vtx_ff[0] <= vtx_rd_ff;
            2'd1: vtx_ff[1] <= vtx_rd_ff;
            default: vtx_ff[2] <= vtx_rd_ff;
         endcase
      end
      if (state_ff == mta_pkg::S_DIFF) begin
         e1_ff[0] <= mta_pkg::sat_diff(vtx_ff[1].x, vtx_ff[0].x);
         e1_ff[1] <= mta_pkg::sat_diff(vtx_ff[1].y, vtx_ff[0].y);
         e1_ff[2] <= mta_pkg::sat_diff(vtx_ff[1].z, vtx_ff[0].z);
         e2_ff[0] <= mta_pkg::sat_diff(vtx_ff[2].x, vtx_ff[0].x);
         e2_ff[1] <= mta_pkg::sat_diff(vtx_ff[2].y, vtx_ff[0].y);
         e2_ff[2] <= mta_pkg::sat_diff(vtx_ff[2].z, vtx_ff[0].z);
         du1_ff <= mta_pkg::sat_diff(vtx_ff[1].u, vtx_ff[0].u);
         dv1_ff <= mta_pkg::sat_diff(vtx_ff[1].v, vtx_ff[0].v);
         du2_ff <= mta_pkg::sat_diff(vtx_ff[2].u, vtx_ff[0].u);
         dv2_ff <= mta_pkg::sat_diff(vtx_ff[2].v, vtx_ff[0].v);
      end
      // pairwise products into determinant and numerators
      if (state_ff == mta_pkg::S_MUL) begin
         case (cnt_ff)
            4'd1, 4'd3, 4'd5, 4'd7: hold_ff <= prod;
            4'd2: res_ff[0] <= 65'(hold_ff - prod);
            4'd4: res_ff[1] <= 65'(hold_ff - prod);
            4'd6: res_ff[2] <= 65'(hold_ff - prod);
            4'd8: res_ff[3] <= 65'(hold_ff - prod);
            default: hold_ff <= hold_ff;
         endcase
      end
      // saturated, signed tangent component
      if ((state_ff == mta_pkg::S_DIV_WAIT) && irsp.done) begin
         case (cnt_ff[1:0])
            2'd0: tan_ff[0] <= (div_num[64] ^ res_ff[0][64])
                  ? -(irsp.sat ? mta_pkg::COMP_LIM : 41'(irsp.quot[38:0]))
                  : (irsp.sat ? mta_pkg::COMP_LIM : 41'(irsp.quot[38:0]));
            2'd1: tan_ff[1] <= (div_num[64] ^ res_ff[0][64])
                  ? -(irsp.sat ? mta_pkg::COMP_LIM : 41'(irsp.quot[38:0]))
                  : (irsp.sat ? mta_pkg::COMP_LIM : 41'(irsp.quot[38:0]));
            default: tan_ff[2] <= (div_num[64] ^ res_ff[0][64])
                  ? -(irsp.sat ? mta_pkg::COMP_LIM : 41'(irsp.quot[38:0]))
                  : (irsp.sat ? mta_pkg::COMP_LIM : 41'(irsp.quot[38:0]));
         endcase
      end
   end

   // readout datapath
   always_ff @(posedge clock) begin
      if (state_ff == mta_pkg::S_RD_ACC) begin
         mag_ff[0] <= acc_rd_ff.x[39] ? 40'(-acc_rd_ff.x) : acc_rd_ff.x;
         mag_ff[1] <= acc_rd_ff.y[39] ? 40'(-acc_rd_ff.y) : acc_rd_ff.y;
         mag_ff[2] <= acc_rd_ff.z[39] ? 40'(-acc_rd_ff.z) : acc_rd_ff.z;
         neg_ff[0] <= acc_rd_ff.x[39];
         neg_ff[1] <= acc_rd_ff.y[39];
         neg_ff[2] <= acc_rd_ff.z[39];
      end
      // shift all magnitudes until the largest fits in 24 bits
      if ((state_ff == mta_pkg::S_NORM) && (mag_or[39:24] != '0)) begin
         mag_ff[0] <= mag_ff[0] >> 1;
         mag_ff[1] <= mag_ff[1] >> 1;
         mag_ff[2] <= mag_ff[2] >> 1;
      end
      // sum of squares
      if (state_ff == mta_pkg::S_NORM) begin
         sum_ff <= '0;
      end else if ((state_ff == mta_pkg::S_SQ) && (cnt_ff != 4'd0)) begin
         sum_ff <= sum_ff + prod[49:0];
      end
      if ((state_ff == mta_pkg::S_SQRT_WAIT) && irsp.done) begin
         len_ff <= irsp.quot[25:0];
      end
      // rounded, signed unit component
      if ((state_ff == mta_pkg::S_NDIV_WAIT) && irsp.done) begin
         case (cnt_ff[1:0])
            2'd0: out_ff[0] <= neg_ff[0] ? -16'(rnd[16:1]) : 16'(rnd[16:1]);
            2'd1: out_ff[1] <= neg_ff[1] ? -16'(rnd[16:1]) : 16'(rnd[16:1]);
            default: out_ff[2] <= neg_ff[2] ? -16'(rnd[16:1]) : 16'(rnd[16:1]);
         endcase
      end
      // zero vector or out-of-range index
      if (req_acc || ((state_ff == mta_pkg::S_NORM) && (mag_or == '0))) begin
         out_ff[0] <= '0;
         out_ff[1] <= '0;
         out_ff[2] <= '0;
         zero_ff <= 1'b1;
      end else if (state_ff == mta_pkg::S_SQ) begin
         zero_ff <= 1'b0;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_load) begin
         rsp_data_ff.vertex_index <= ridx_ff;
         rsp_data_ff.tangent_x <= out_ff[0];
         rsp_data_ff.tangent_y <= out_ff[1];
         rsp_data_ff.tangent_z <= out_ff[2];
         rsp_data_ff.zero_length <= zero_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule

[src/mta_mul.sv]
module mta_mul (
   input  logic clock,
   input  logic signed [32:0] op_a,
   input  logic signed [32:0] op_b,
   output logic signed [65:0] prod
);

   logic signed [65:0] prod_ff;

   // registered signed product
   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

   assign prod = prod_ff;

endmodule

[src/mta_iter.sv]
module mta_iter (
   input  logic clock,
   input  logic reset,
   input  mta_pkg::iter_req_type ireq,
   output mta_pkg::iter_rsp_type irsp
);

   logic busy_ff;
   logic done_ff;
   mta_pkg::iter_op_type op_ff;
   logic [mta_pkg::CNT_W-1:0] cnt_ff;
   logic [mta_pkg::NUM_W-1:0] num_ff;
   logic [mta_pkg::REM_W-1:0] div_ff;
   logic [mta_pkg::REM_W-1:0] rem_ff;
   logic [mta_pkg::REM_W-1:0] q_ff;
   logic sat_ff;

   logic [mta_pkg::REM_W:0] trial;
   logic div_ge;
   logic [mta_pkg::REM_W-1:0] sq_t;
   logic sq_ge;

   // one restoring step: a quotient bit or a root bit
   always_comb begin
      trial = {rem_ff, num_ff[mta_pkg::NUM_W-1]};
      div_ge = trial >= {1'b0, div_ff};
      sq_t = q_ff + num_ff[mta_pkg::REM_W-1:0];
      sq_ge = rem_ff >= sq_t;
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == 7'd1);
         if (ireq.start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (cnt_ff == 7'd1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (ireq.start) begin
         op_ff <= ireq.op;
         cnt_ff <= ireq.count;
         div_ff <= ireq.divisor;
         q_ff <= '0;
         sat_ff <= 1'b0;
         if (ireq.op == mta_pkg::OP_DIV) begin
            num_ff <= ireq.dividend;
            rem_ff <= '0;
         end else begin
            num_ff <= mta_pkg::SQRT_BIT0;
            rem_ff <= ireq.dividend[mta_pkg::REM_W-1:0];
         end
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 7'd1;
         if (op_ff == mta_pkg::OP_DIV) begin
            rem_ff <= div_ge ? mta_pkg::REM_W'(trial - {1'b0, div_ff})
                             : trial[mta_pkg::REM_W-1:0];
            q_ff <= {24'b0, q_ff[38:0], div_ge};
            sat_ff <= sat_ff | q_ff[39];
            num_ff <= num_ff << 1;
         end else begin
            if (sq_ge) begin
               rem_ff <= rem_ff - sq_t;
               q_ff <= (q_ff >> 1) + num_ff[mta_pkg::REM_W-1:0];
            end else begin
               q_ff <= q_ff >> 1;
            end
            num_ff <= num_ff >> 2;
         end
      end
   end

   assign irsp.done = done_ff;
   assign irsp.quot = q_ff;
   assign irsp.sat = sat_ff | q_ff[39];

endmodule
